// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond implies resp on the next edge, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, resp, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (resp)) \
        else $error(msg);

`endif

// ===== rtl/core/dhcpopt_pkg.sv =====
package dhcpopt_pkg;

    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'hff;
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OFFER_CODE   = 8'd2;
    localparam logic [7:0] MSG_TYPE_LEN = 8'd1;
    localparam logic [7:0] OPT_MASK     = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;

    localparam logic [1:0] HEADER_LEN   = 2'd3;
    localparam logic [2:0] CAPTURE_LEN  = 3'd4;

    localparam logic [1:0] STATUS_OFFER     = 2'd0;
    localparam logic [1:0] STATUS_NOT_OFFER = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0]  opt_byte;
        logic        first;
        logic        last;
        logic [31:0] offered_address;
        logic [31:0] server_address;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offered_ip;
        logic [31:0] server_ip;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic        have_mask;
        logic        have_router;
        logic        have_dns;
    } result_t;

    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = OPT_MSG_TYPE;
            2'd1:    val = MSG_TYPE_LEN;
            2'd2:    val = OFFER_CODE;
            default: val = OPT_PAD;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/dhcp_offer_option_parser.sv =====
// DHCP offer option parser.
// Input channel: item_valid / item_stall / item, one options byte per
// transaction, with first and last marking message bounds; the offered and
// server addresses are taken with the first byte.
// Output channel: result_valid / result_stall / result, at most one
// transaction per message: at the end code, at a header mismatch, or at the
// last byte when neither came first.
// Latency: a result is shown on the cycle after the byte that causes it.
// Throughput: one byte per cycle; the per-byte state update is a single
// pass of logic between the parse state registers and the result register.
// item_stall rises only while a result is held and result_stall is high;
// then the result and the parse state hold until the result is taken.
// Reset clears the parse state and drops any held result; bytes before the
// next first are ignored, as are bytes after a message's result.
module dhcp_offer_option_parser
    import dhcpopt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  cur_code_reg, cur_code_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [2:0]  val_idx_reg, val_idx_next;
    logic [31:0] val_acc_reg, val_acc_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] dns_reg, dns_next;
    logic [2:0]  found_reg, found_next;
    logic [31:0] offer_reg, offer_next;
    logic [31:0] server_reg, server_next;

    logic        result_valid_reg, result_valid_next;
    result_t     result_reg;

    logic        accept;
    logic        emit;
    logic [1:0]  emit_status;

    assign item_stall   = result_valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        phase_t     cur_phase;
        logic [7:0] b;
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        cur_code_next  = cur_code_reg;
        remaining_next = remaining_reg;
        val_idx_next   = val_idx_reg;
        val_acc_next   = val_acc_reg;
        mask_next      = mask_reg;
        router_next    = router_reg;
        dns_next       = dns_reg;
        found_next     = found_reg;
        offer_next     = offer_reg;
        server_next    = server_reg;
        emit           = 1'b0;
        emit_status    = STATUS_OFFER;
        b              = item.opt_byte;
        cur_phase      = phase_reg;

        if (item.first)
        begin
            hdr_cnt_next   = 2'd0;
            cur_code_next  = 8'd0;
            remaining_next = 8'd0;
            val_idx_next   = 3'd0;
            val_acc_next   = 32'd0;
            mask_next      = 32'd0;
            router_next    = 32'd0;
            dns_next       = 32'd0;
            found_next     = 3'd0;
            offer_next     = item.offered_address;
            server_next    = item.server_address;
            cur_phase      = PH_HEADER;
            phase_next     = PH_HEADER;
        end

        case (cur_phase)
            PH_HEADER:
            begin
                if (b != header_byte(hdr_cnt_next))
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_NOT_OFFER;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_next + 2'd1;
                    if (hdr_cnt_next == HEADER_LEN)
                    begin
                        phase_next = PH_CODE;
                    end
                end
            end
            PH_CODE:
            begin
                if (b == OPT_END)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_OFFER;
                end
                else if (b != OPT_PAD)
                begin
                    cur_code_next = b;
                    phase_next    = PH_LEN;
                end
            end
            PH_LEN:
            begin
                remaining_next = b;
                val_idx_next   = 3'd0;
                val_acc_next   = 32'd0;
                phase_next     = (b == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE:
            begin
                if (val_idx_reg < CAPTURE_LEN)
                begin
                    val_acc_next = {val_acc_reg[23:0], b};
                    val_idx_next = val_idx_reg + 3'd1;
                end
                remaining_next = remaining_reg - 8'd1;
                if (remaining_next == 8'd0)
                begin
                    if (val_idx_next == CAPTURE_LEN)
                    begin
                        if (cur_code_reg == OPT_MASK)
                        begin
                            mask_next     = val_acc_next;
                            found_next[0] = 1'b1;
                        end
                        else if (cur_code_reg == OPT_ROUTER)
                        begin
                            router_next   = val_acc_next;
                            found_next[1] = 1'b1;
                        end
                        else if (cur_code_reg == OPT_DNS)
                        begin
                            dns_next      = val_acc_next;
                            found_next[2] = 1'b1;
                        end
                    end
                    phase_next = PH_CODE;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase

        if (!emit && item.last && (cur_phase != PH_IDLE) && (cur_phase != PH_DONE))
        begin
            emit        = 1'b1;
            emit_status = STATUS_TRUNCATED;
        end

        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    assign result_valid_next = (accept & emit) | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            hdr_cnt_reg      <= 2'd0;
            cur_code_reg     <= 8'd0;
            remaining_reg    <= 8'd0;
            val_idx_reg      <= 3'd0;
            val_acc_reg      <= 32'd0;
            mask_reg         <= 32'd0;
            router_reg       <= 32'd0;
            dns_reg          <= 32'd0;
            found_reg        <= 3'd0;
            offer_reg        <= 32'd0;
            server_reg       <= 32'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                cur_code_reg  <= cur_code_next;
                remaining_reg <= remaining_next;
                val_idx_reg   <= val_idx_next;
                val_acc_reg   <= val_acc_next;
                mask_reg      <= mask_next;
                router_reg    <= router_next;
                dns_reg       <= dns_next;
                found_reg     <= found_next;
                offer_reg     <= offer_next;
                server_reg    <= server_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg.status      <= emit_status;
            result_reg.offered_ip  <= offer_next;
            result_reg.server_ip   <= server_next;
            result_reg.subnet_mask <= mask_next;
            result_reg.router_addr <= router_next;
            result_reg.dns_addr    <= dns_next;
            result_reg.have_mask   <= found_next[0];
            result_reg.have_router <= found_next[1];
            result_reg.have_dns    <= found_next[2];
        end
    end

endmodule

// ===== rtl/core/dhcp_offer_option_parser_checker.sv =====
`include "assert_macros.svh"

module dhcp_offer_option_parser_checker
    import dhcpopt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // held result must stay put until taken
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

    // input backs up only behind a stalled result
    `ASSERT_CLK(a_stall_cause, clk, rst_n, item_stall == (result_valid && result_stall), "item_stall does not follow the held result")

    `ASSERT_CLK(a_status_code, clk, rst_n, result_valid |-> (result.status == STATUS_OFFER || result.status == STATUS_NOT_OFFER || result.status == STATUS_TRUNCATED), "undefined status code")

    // a rejected header carries no captures
    `ASSERT_CLK(a_reject_clean, clk, rst_n, (result_valid && result.status == STATUS_NOT_OFFER) |-> (!result.have_mask && !result.have_router && !result.have_dns && result.subnet_mask == 32'd0 && result.router_addr == 32'd0 && result.dns_addr == 32'd0), "capture fields set on rejected message")

endmodule

bind dhcp_offer_option_parser dhcp_offer_option_parser_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== bench/dhcp_offer_option_parser_tb.sv =====
`timescale 1ns / 1ps

module dhcp_offer_option_parser_tb;
    import dhcpopt_pkg::*;

    localparam int MAX_CYCLES  = 400000;
    localparam int HOLD_CYCLES = 150;

    class offer_scoreboard;
        result_t     pending_reports [$];
        phase_t      phase;
        logic [1:0]  hdr_count;
        logic [7:0]  opt_code;
        logic [7:0]  remain;
        logic [2:0]  val_count;
        logic [31:0] val_acc;
        logic [31:0] mask_val;
        logic [31:0] router_val;
        logic [31:0] dns_val;
        logic [2:0]  found;
        logic [31:0] offer_ip;
        logic [31:0] server_ip;
        int          errors;
        int          n_predicted;
        int          n_checked;

        function new();
            clear_message();
            errors = 0;
            n_predicted = 0;
            n_checked = 0;
        endfunction

        function void clear_message();
            phase = PH_IDLE;
            hdr_count = '0;
            opt_code = '0;
            remain = '0;
            val_count = '0;
            val_acc = '0;
            mask_val = '0;
            router_val = '0;
            dns_val = '0;
            found = '0;
            offer_ip = '0;
            server_ip = '0;
        endfunction

        function void note_byte(item_t it);
            logic [1:0] st;
            logic [7:0] hdr_want;
            bit         rep;
            result_t    r;
            rep = 1'b0;
            st = STATUS_OFFER;
            if (it.first)
            begin
                clear_message();
                offer_ip = it.offered_address;
                server_ip = it.server_address;
                phase = PH_HEADER;
            end
            case (phase)
                PH_HEADER:
                begin
                    hdr_want = (hdr_count == 2'd0) ? OPT_MSG_TYPE :
                               ((hdr_count == 2'd1) ? MSG_TYPE_LEN : OFFER_CODE);
                    if (it.opt_byte != hdr_want)
                    begin
                        st = STATUS_NOT_OFFER;
                        rep = 1'b1;
                    end
                    else
                    begin
                        hdr_count++;
                        if (hdr_count == HEADER_LEN)
                            phase = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    if (it.opt_byte == OPT_END)
                    begin
                        st = STATUS_OFFER;
                        rep = 1'b1;
                    end
                    else if (it.opt_byte != OPT_PAD)
                    begin
                        opt_code = it.opt_byte;
                        phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    remain = it.opt_byte;
                    val_count = '0;
                    val_acc = '0;
                    phase = (it.opt_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (val_count < CAPTURE_LEN)
                    begin
                        val_acc = {val_acc[23:0], it.opt_byte};
                        val_count++;
                    end
                    remain = remain - 8'd1;
                    if (remain == 8'd0)
                    begin
                        if (val_count == CAPTURE_LEN)
                        begin
                            case (opt_code)
                                OPT_MASK:
                                begin
                                    mask_val = val_acc;
                                    found[0] = 1'b1;
                                end
                                OPT_ROUTER:
                                begin
                                    router_val = val_acc;
                                    found[1] = 1'b1;
                                end
                                OPT_DNS:
                                begin
                                    dns_val = val_acc;
                                    found[2] = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        phase = PH_CODE;
                    end
                end
                default: return;
            endcase
            if (!rep && it.last)
            begin
                st = STATUS_TRUNCATED;
                rep = 1'b1;
            end
            if (rep)
            begin
                r.status = st;
                r.offered_ip = offer_ip;
                r.server_ip = server_ip;
                r.subnet_mask = mask_val;
                r.router_addr = router_val;
                r.dns_addr = dns_val;
                r.have_mask = found[0];
                r.have_router = found[1];
                r.have_dns = found[2];
                pending_reports.push_back(r);
                n_predicted++;
                phase = PH_DONE;
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result transaction with none expected, status %0d", got.status);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            n_checked++;
            compare("status", 32'(want.status), 32'(got.status));
            compare("offered_ip", want.offered_ip, got.offered_ip);
            compare("server_ip", want.server_ip, got.server_ip);
            compare("subnet_mask", want.subnet_mask, got.subnet_mask);
            compare("router_addr", want.router_addr, got.router_addr);
            compare("dns_addr", want.dns_addr, got.dns_addr);
            compare("have_mask", 32'(want.have_mask), 32'(got.have_mask));
            compare("have_router", 32'(want.have_router), 32'(got.have_router));
            compare("have_dns", 32'(want.have_dns), 32'(got.have_dns));
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic    hold_off = 1'b0;
    bit      pressure_go = 1'b0;
    int      send_idle_pct = 18;
    int      recv_idle_pct = 74;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    logic [7:0] msg_bytes [$];

    offer_scoreboard offer_sb;

    dhcp_offer_option_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            offer_sb.note_byte(item);
        if (rst_n && result_valid && !result_stall)
            offer_sb.check_result(result);
    end

    always @(negedge clk)
        result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // hold the output off long enough for the input to back up
    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] octet, input logic is_first,
                             input logic is_last, input logic [31:0] offer_addr,
                             input logic [31:0] server_addr);
        item_t it;
        it.opt_byte = octet;
        it.first = is_first;
        it.last = is_last;
        it.offered_address = offer_addr;
        it.server_address = server_addr;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_msg(input int count, input logic mark_last,
                            input logic [31:0] offer_addr, input logic [31:0] server_addr);
        for (int i = 0; i < count; i++)
            send_byte(msg_bytes[i], i == 0, mark_last && (i == count - 1),
                      (i == 0) ? offer_addr : $urandom, (i == 0) ? server_addr : $urandom);
        msg_bytes.delete();
    endtask

    task automatic push_header();
        msg_bytes.push_back(OPT_MSG_TYPE);
        msg_bytes.push_back(MSG_TYPE_LEN);
        msg_bytes.push_back(OFFER_CODE);
    endtask

    task automatic push_options();
        int         n;
        int         roll;
        int         len;
        logic [7:0] code;
        n = $urandom_range(4);
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
                msg_bytes.push_back(OPT_PAD);
            else
            begin
                if (roll < 75)
                begin
                    case ($urandom_range(2))
                        0: code = OPT_MASK;
                        1: code = OPT_ROUTER;
                        default: code = OPT_DNS;
                    endcase
                    len = (roll < 62) ? 4 : $urandom_range(8);
                end
                else
                begin
                    code = 8'($urandom_range(1, 254));
                    len = (roll < 99) ? $urandom_range(10) : $urandom_range(255);
                end
                msg_bytes.push_back(code);
                msg_bytes.push_back(len[7:0]);
                repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic random_message();
        int roll;
        int k;
        roll = $urandom_range(99);
        msg_bytes.delete();
        push_header();
        if (roll < 55)
        begin
            push_options();
            msg_bytes.push_back(OPT_END);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(255)));
            send_msg(msg_bytes.size(), 1'($urandom_range(1)), $urandom, $urandom);
        end
        else if (roll < 72)
        begin
            push_options();
            push_options();
            send_msg($urandom_range(1, msg_bytes.size()), 1'b1, $urandom, $urandom);
        end
        else if (roll < 84)
        begin
            k = $urandom_range(2);
            msg_bytes[k] = msg_bytes[k] ^ 8'($urandom_range(1, 255));
            push_options();
            msg_bytes.push_back(OPT_END);
            send_msg(msg_bytes.size(), 1'($urandom_range(1)), $urandom, $urandom);
        end
        else if (roll < 92)
        begin
            // drop mid-message; the next first restarts parsing
            push_options();
            send_msg(msg_bytes.size(), 1'b0, $urandom, $urandom);
        end
        else
        begin
            msg_bytes.delete();
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(255)), $urandom_range(5) == 0,
                          $urandom_range(5) == 0, $urandom, $urandom);
        end
    endtask

    initial
    begin
        offer_sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_byte(OPT_END, 1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        msg_bytes = '{OPT_MSG_TYPE, MSG_TYPE_LEN, OFFER_CODE,
                      OPT_MASK, 8'd4, 8'hff, 8'hff, 8'hff, 8'hff,
                      OPT_PAD,
                      OPT_ROUTER, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00,
                      OPT_END};
        send_msg(msg_bytes.size(), 1'b1, 32'hffff_ffff, 32'h0000_0000);
        msg_bytes = '{OPT_MSG_TYPE + 8'd1, OPT_MSG_TYPE};
        send_msg(2, 1'b0, 32'h0000_0000, 32'hffff_ffff);
        msg_bytes = '{OPT_MSG_TYPE, MSG_TYPE_LEN, OFFER_CODE, OPT_DNS};
        send_msg(4, 1'b0, $urandom, $urandom);
        msg_bytes = '{OPT_MSG_TYPE, MSG_TYPE_LEN, OFFER_CODE,
                      OPT_DNS, 8'd4, 8'h0a, 8'h01, 8'h02, 8'h03};
        send_msg(9, 1'b1, $urandom, $urandom);
        msg_bytes = '{OPT_MSG_TYPE, MSG_TYPE_LEN};
        send_msg(2, 1'b1, $urandom, $urandom);

        while (bytes_sent < 170)
            random_message();

        send_idle_pct = 74;
        recv_idle_pct = 18;
        while (bytes_sent < 320)
            random_message();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_go = 1'b1;
        repeat (8) send_byte(OPT_END, 1'b1, 1'b0, $urandom, $urandom);
        while (bytes_sent < 450)
            random_message();

        @(negedge clk);
        item_valid <= 1'b0;
        while (offer_sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d byte transactions and %0d message results", bytes_sent,
                 offer_sb.n_checked);
        $display("over three idle patterns and one long output hold-off.");
        if (offer_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dhcpopt_pkg.sv
rtl/core/dhcp_offer_option_parser.sv
rtl/core/dhcp_offer_option_parser_checker.sv
bench/dhcp_offer_option_parser_tb.sv
